/* hw/rtl/cht_pkg.sv */
// Shared constants, types and helper functions of the chained hash table unit.
`default_nettype none

package cht_pkg;

    // Default table geometry.
    localparam int unsigned CHT_BUCKETS = 64;
    localparam int unsigned CHT_NODES   = 256;

    // Fixed field widths.
    localparam int unsigned KEY_W    = 31;
    localparam int unsigned STATUS_W = 2;

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t STATUS_DONE      = 2'd0;
    localparam status_t STATUS_NOT_FOUND = 2'd1;
    localparam status_t STATUS_FULL      = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    clr;        // clear one bucket head during the reset sweep
        logic    load;       // capture op and key, start hashing
        logic    take;       // pop a free node and initialise it
        logic    link_head;  // new node becomes the head of an empty bucket
        logic    walk_step;  // advance the insert walk by one node
        logic    link_tail;  // append the new node after the current tail
        logic    del_first;  // start the delete walk at the bucket head
        logic    del_step;   // advance the delete walk by one node
        logic    unlink;     // remove the matching node and free it
        logic    set_res;    // record the result code
        status_t res;
        logic    out_load;   // move the recorded code to the output register
    } cht_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic hash_done;
        logic is_delete;
        logic full;
        logic head_null;
        logic nx_null;
        logic key_match;
        logic prev_null;
    } cht_sts_t;

    // Address width for a store of the given depth, never below one bit.
    function automatic int unsigned addr_width(input int unsigned depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/cht_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module cht_ram
    import cht_pkg::*;
#(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
)
(
    input  wire logic                          clk,
    input  wire logic                          we,
    input  wire logic [addr_width(DEPTH)-1:0]  waddr,
    input  wire logic [WIDTH-1:0]              wdata,
    input  wire logic [addr_width(DEPTH)-1:0]  raddr,
    output logic      [WIDTH-1:0]              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read; a read of the address being written returns the old word.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* hw/rtl/cht_rem.sv */
// Bucket index unit: key modulo the bucket count.
`default_nettype none

module cht_rem
    import cht_pkg::*;
#(
    parameter int unsigned BUCKETS = CHT_BUCKETS
)
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    input  wire logic [KEY_W-1:0]                 key,
    output logic                                  done,
    output logic      [addr_width(BUCKETS)-1:0]   bucket
);

    localparam int unsigned BKT_W = addr_width(BUCKETS);
    localparam bit          POW2  = (BUCKETS > 1) && ((BUCKETS & (BUCKETS - 1)) == 0);

    generate
        if (POW2)
        begin : g_mask
            logic             done_reg;
            logic [BKT_W-1:0] bucket_reg;

            // A power-of-two count needs only the low bits of the key.
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    done_reg <= 1'b0;
                end
                else
                begin
                    done_reg <= start;
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    bucket_reg <= key[BKT_W-1:0];
                end
            end

            assign done   = done_reg;
            assign bucket = bucket_reg;
        end
        else
        begin : g_recip
            // Rounded-up reciprocal of the bucket count, exact for every key of KEY_W bits.
            localparam int unsigned      LOG_B      = $clog2(BUCKETS);
            localparam int unsigned      SH         = KEY_W + LOG_B;
            localparam int unsigned      QW         = KEY_W - LOG_B + 1;
            localparam int unsigned      PROD_W     = 2 * KEY_W + 1;
            localparam logic [63:0]      RECIP_FULL =
                ((64'd1 << SH) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
            localparam logic [KEY_W:0]   RECIP      = RECIP_FULL[KEY_W:0];
            localparam logic [BKT_W-1:0] BKT_LOW    = BKT_W'(BUCKETS);

            logic              stage1_reg;
            logic              stage2_reg;
            logic              done_reg;
            logic [KEY_W-1:0]  key_reg;
            logic [QW-1:0]     q_reg;
            logic [BKT_W-1:0]  r_reg;
            logic [PROD_W-1:0] prod;

            assign prod = PROD_W'(key_reg) * PROD_W'(RECIP);

            // Two-stage pipeline flags and completion pulse.
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    stage1_reg <= 1'b0;
                    stage2_reg <= 1'b0;
                    done_reg   <= 1'b0;
                end
                else
                begin
                    stage1_reg <= start;
                    stage2_reg <= stage1_reg;
                    done_reg   <= stage2_reg;
                end
            end

            // Quotient first; the remainder lies below the bucket count, so its low
            // bits alone are enough to form it.
            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    key_reg <= key;
                end
                if (stage1_reg)
                begin
                    q_reg <= prod[SH +: QW];
                end
                if (stage2_reg)
                begin
                    r_reg <= key_reg[BKT_W-1:0] - q_reg[BKT_W-1:0] * BKT_LOW;
                end
            end

            assign done   = done_reg;
            assign bucket = r_reg;
        end
    endgenerate

endmodule

`default_nettype wire

/* hw/rtl/cht_dp.sv */
// Datapath of the chained hash table: table memories, free pool and walk registers.
`default_nettype none

module cht_dp
    import cht_pkg::*;
#(
    parameter int unsigned BUCKETS = CHT_BUCKETS,
    parameter int unsigned NODES   = CHT_NODES
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire cht_cmd_t         cmd,
    output cht_sts_t              sts,
    input  wire logic             op,
    input  wire logic [KEY_W-1:0] key,
    output status_t               status
);

    localparam int unsigned BKT_W = addr_width(BUCKETS);
    localparam int unsigned IDX_W = addr_width(NODES);
    localparam int unsigned PTR_W = $clog2(NODES + 1);

    // Null pointer is the node count itself.
    localparam logic [PTR_W-1:0] NIL = PTR_W'(NODES);

    // Control registers
    logic [BKT_W-1:0] clr_cnt_reg;
    logic [PTR_W-1:0] fc_reg;
    logic [PTR_W-1:0] lw_reg;

    // Item registers
    logic             op_reg;
    logic [KEY_W-1:0] key_reg;
    logic [PTR_W-1:0] cur_reg;
    logic [PTR_W-1:0] prev_reg;
    logic [IDX_W-1:0] n_reg;
    status_t          res_reg;
    status_t          status_reg;

    // Hashing
    logic             hash_done;
    logic [BKT_W-1:0] bucket;

    // Memory ports
    logic             bkt_we;
    logic [BKT_W-1:0] bkt_waddr;
    logic [PTR_W-1:0] bkt_wdata;
    logic [PTR_W-1:0] bkt_rdata;

    logic             nk_we;
    logic [KEY_W-1:0] nk_rdata;

    logic             nn_we;
    logic [IDX_W-1:0] nn_waddr;
    logic [PTR_W-1:0] nn_wdata;
    logic [PTR_W-1:0] nn_rdata;
    logic [IDX_W-1:0] node_raddr;

    logic             fs_we;
    logic [IDX_W-1:0] fs_rdata;
    logic [IDX_W-1:0] fs_raddr;

    logic [PTR_W-1:0] pop_idx;
    logic             pop_fresh;
    logic [IDX_W-1:0] n_comb;
    logic             push_ok;

    cht_rem #(
        .BUCKETS (BUCKETS)
    ) u_rem (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.load),
        .key    (key),
        .done   (hash_done),
        .bucket (bucket)
    );

    // Free stack top; entries below the lowest fill level ever reached still hold their own index.
    assign pop_idx   = fc_reg - PTR_W'(1);
    assign pop_fresh = pop_idx < lw_reg;
    assign n_comb    = pop_fresh ? pop_idx[IDX_W-1:0] : fs_rdata;
    assign fs_raddr  = pop_idx[IDX_W-1:0];
    assign push_ok   = fc_reg < NIL;

    // Bucket head writes: reset sweep, new head on insert, unlink of the head on delete.
    always_comb
    begin
        bkt_we    = 1'b0;
        bkt_waddr = bucket;
        bkt_wdata = nn_rdata;
        if (cmd.clr)
        begin
            bkt_we    = 1'b1;
            bkt_waddr = clr_cnt_reg;
            bkt_wdata = NIL;
        end
        else if (cmd.link_head)
        begin
            bkt_we    = 1'b1;
            bkt_wdata = PTR_W'(n_comb);
        end
        else if (cmd.unlink && (prev_reg == NIL))
        begin
            bkt_we = 1'b1;
        end
    end

    // Next-pointer writes: terminate a new node, append at the tail, unlink mid-chain.
    always_comb
    begin
        nn_we    = 1'b0;
        nn_waddr = n_comb;
        nn_wdata = NIL;
        if (cmd.take)
        begin
            nn_we = 1'b1;
        end
        else if (cmd.link_tail)
        begin
            nn_we    = 1'b1;
            nn_waddr = cur_reg[IDX_W-1:0];
            nn_wdata = PTR_W'(n_reg);
        end
        else if (cmd.unlink && (prev_reg != NIL))
        begin
            nn_we    = 1'b1;
            nn_waddr = prev_reg[IDX_W-1:0];
            nn_wdata = nn_rdata;
        end
    end

    assign nk_we = cmd.take;
    assign fs_we = cmd.unlink && push_ok;

    // Node reads follow the bucket head at the start of a walk, the next pointer after.
    assign node_raddr = (cmd.take || cmd.del_first) ? bkt_rdata[IDX_W-1:0]
                                                    : nn_rdata[IDX_W-1:0];

    cht_ram #(
        .WIDTH (PTR_W),
        .DEPTH (BUCKETS)
    ) u_bucket_head (
        .clk   (clk),
        .we    (bkt_we),
        .waddr (bkt_waddr),
        .wdata (bkt_wdata),
        .raddr (bucket),
        .rdata (bkt_rdata)
    );

    cht_ram #(
        .WIDTH (KEY_W),
        .DEPTH (NODES)
    ) u_node_key (
        .clk   (clk),
        .we    (nk_we),
        .waddr (n_comb),
        .wdata (key_reg),
        .raddr (node_raddr),
        .rdata (nk_rdata)
    );

    cht_ram #(
        .WIDTH (PTR_W),
        .DEPTH (NODES)
    ) u_node_next (
        .clk   (clk),
        .we    (nn_we),
        .waddr (nn_waddr),
        .wdata (nn_wdata),
        .raddr (node_raddr),
        .rdata (nn_rdata)
    );

    cht_ram #(
        .WIDTH (IDX_W),
        .DEPTH (NODES)
    ) u_free_stack (
        .clk   (clk),
        .we    (fs_we),
        .waddr (fc_reg[IDX_W-1:0]),
        .wdata (cur_reg[IDX_W-1:0]),
        .raddr (fs_raddr),
        .rdata (fs_rdata)
    );

    // Sweep counter, free count and low-water mark of the free stack.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            fc_reg      <= NIL;
            lw_reg      <= NIL;
        end
        else
        begin
            if (cmd.clr)
            begin
                clr_cnt_reg <= clr_cnt_reg + BKT_W'(1);
            end
            if (cmd.take)
            begin
                fc_reg <= pop_idx;
                if (pop_fresh)
                begin
                    lw_reg <= pop_idx;
                end
            end
            else if (cmd.unlink && push_ok)
            begin
                fc_reg <= fc_reg + PTR_W'(1);
            end
        end
    end

    // Item, walk and result registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= op;
            key_reg <= key;
        end
        if (cmd.take)
        begin
            n_reg   <= n_comb;
            cur_reg <= bkt_rdata;
        end
        if (cmd.walk_step)
        begin
            cur_reg <= nn_rdata;
        end
        if (cmd.del_first)
        begin
            cur_reg  <= bkt_rdata;
            prev_reg <= NIL;
        end
        if (cmd.del_step)
        begin
            prev_reg <= cur_reg;
            cur_reg  <= nn_rdata;
        end
        if (cmd.set_res)
        begin
            res_reg <= cmd.res;
        end
        if (cmd.out_load)
        begin
            status_reg <= res_reg;
        end
    end

    // Status towards the controller.
    always_comb
    begin
        sts.clr_last  = clr_cnt_reg == BKT_W'(BUCKETS - 1);
        sts.hash_done = hash_done;
        sts.is_delete = op_reg;
        sts.full      = fc_reg == '0;
        sts.head_null = bkt_rdata == NIL;
        sts.nx_null   = nn_rdata == NIL;
        sts.key_match = nk_rdata == key_reg;
        sts.prev_null = prev_reg == NIL;
    end

    assign status = status_reg;

endmodule

`default_nettype wire

/* hw/rtl/cht_ctrl.sv */
// Controller of the chained hash table: sequencing of hashing, chain walks and the handshakes.
`default_nettype none

module cht_ctrl
    import cht_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  wire logic     out_ready,
    output cht_cmd_t      cmd,
    input  wire cht_sts_t sts
);

    localparam logic [3:0] S_CLEAR     = 4'd0;
    localparam logic [3:0] S_IDLE      = 4'd1;
    localparam logic [3:0] S_HASH      = 4'd2;
    localparam logic [3:0] S_TAKE      = 4'd3;
    localparam logic [3:0] S_WALK      = 4'd4;
    localparam logic [3:0] S_DEL_FIRST = 4'd5;
    localparam logic [3:0] S_DEL_CMP   = 4'd6;
    localparam logic [3:0] S_RESP      = 4'd7;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                // The bucket head and free stack top are read as the hash completes.
                if (sts.hash_done)
                begin
                    if (sts.is_delete)
                    begin
                        state_next = S_DEL_FIRST;
                    end
                    else if (sts.full)
                    begin
                        cmd.set_res = 1'b1;
                        cmd.res     = STATUS_FULL;
                        state_next  = S_RESP;
                    end
                    else
                    begin
                        state_next = S_TAKE;
                    end
                end
            end
            S_TAKE:
            begin
                cmd.take = 1'b1;
                if (sts.head_null)
                begin
                    cmd.link_head = 1'b1;
                    cmd.set_res   = 1'b1;
                    cmd.res       = STATUS_DONE;
                    state_next    = S_RESP;
                end
                else
                begin
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (sts.nx_null)
                begin
                    cmd.link_tail = 1'b1;
                    cmd.set_res   = 1'b1;
                    cmd.res       = STATUS_DONE;
                    state_next    = S_RESP;
                end
                else
                begin
                    cmd.walk_step = 1'b1;
                end
            end
            S_DEL_FIRST:
            begin
                if (sts.head_null)
                begin
                    cmd.set_res = 1'b1;
                    cmd.res     = STATUS_NOT_FOUND;
                    state_next  = S_RESP;
                end
                else
                begin
                    cmd.del_first = 1'b1;
                    state_next    = S_DEL_CMP;
                end
            end
            S_DEL_CMP:
            begin
                if (sts.key_match)
                begin
                    cmd.unlink  = 1'b1;
                    cmd.set_res = 1'b1;
                    cmd.res     = STATUS_DONE;
                    state_next  = S_RESP;
                end
                else if (sts.nx_null)
                begin
                    cmd.set_res = 1'b1;
                    cmd.res     = STATUS_NOT_FOUND;
                    state_next  = S_RESP;
                end
                else
                begin
                    cmd.del_step = 1'b1;
                end
            end
            S_RESP:
            begin
                // Hand the result over as soon as the output register is free,
                // and take the next item in the same cycle.
                if (slot_free)
                begin
                    cmd.out_load = 1'b1;
                    in_ready     = 1'b1;
                    if (in_valid)
                    begin
                        cmd.load   = 1'b1;
                        state_next = S_HASH;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid flag.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

/* hw/rtl/chained_hash_table_unit.sv */
// Top level of the chained hash table unit: controller, datapath and checks.
//
// Usage: each transfer on the input channel carries an op (0 insert, 1 delete) and a key.
// Every item gives exactly one transfer on the output channel with a status: done, key
// not found on delete, or node pool full on insert. Keys go to bucket key mod BUCKETS;
// inserts append at the tail of the chain, deletes remove the first matching node.
// Items are handled one at a time. An insert walks the nodes already in the bucket to
// the tail, or answers right after hashing if the pool is full; a delete walks up to the
// matching node, or the whole chain when the key is absent. The chain walk through node
// memory advances one node per cycle. When BUCKETS is not a power of two the key
// remainder unit forms the bucket through quotient and remainder registers.
// The next item is taken in the cycle the result enters the output register.
// After reset the bucket heads are cleared in a sweep, during which in_ready stays low.
// If the receiver stalls, the result is held in the output register; one further item
// may be accepted and processed, and then waits for the register.
`default_nettype none

module chained_hash_table_unit
    import cht_pkg::*;
#(
    parameter int unsigned BUCKETS = CHT_BUCKETS,
    parameter int unsigned NODES   = CHT_NODES
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic             op,
    input  wire logic [KEY_W-1:0] key,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output status_t               status
);

    cht_cmd_t cmd;
    cht_sts_t sts;

    cht_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    cht_dp #(
        .BUCKETS (BUCKETS),
        .NODES   (NODES)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .sts    (sts),
        .op     (op),
        .key    (key),
        .status (status)
    );

`ifndef SYNTHESIS
    // Only one item is in work: right after a transfer in, no further item is taken.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second item accepted while one is in work");

    // A result never overwrites one still waiting for the receiver.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid || out_ready))
        else $error("result register overwritten while stalled");

    // A node is only taken from a pool that still has one.
    a_pool_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take |-> !sts.full)
        else $error("node taken from an empty pool");
`endif

endmodule

`default_nettype wire
